### sv/ucb1_pkg.sv
// ----------------------------------------------------------------------------
// ucb1_pkg
// Shared types and constants for the UCB1 child selection block.
// ----------------------------------------------------------------------------
package ucb1_pkg;

  localparam int unsigned DivW   = 48;
  localparam int unsigned DenW   = 24;
  localparam int unsigned IterW  = 6;

  localparam logic [15:0] LN2_Q16 = 16'd45426;
  localparam logic signed [47:0] START_BOUND     = 48'sd655360000;
  localparam logic signed [47:0] UNVISITED_VALUE = 48'sd6553600000;
  localparam logic signed [47:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] VAL_MIN = 48'sh8000_0000_0000;
  localparam logic [23:0] EXPLORE_RESET = 24'd65536;

  localparam logic [IterW-1:0] MEAN_ITERS = 6'd48;
  localparam logic [IterW-1:0] Q_ITERS    = 6'd21;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_EVAL  = 13'b0000000000010,
    S_MEAN  = 13'b0000000000100,
    S_SQ    = 13'b0000000001000,
    S_SQU   = 13'b0000000010000,
    S_LNMUL = 13'b0000000100000,
    S_LNGET = 13'b0000001000000,
    S_QDIV  = 13'b0000010000000,
    S_SQRT  = 13'b0000100000000,
    S_TMUL  = 13'b0001000000000,
    S_TADD  = 13'b0010000000000,
    S_CMP   = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_t;

  typedef struct packed {
    logic             start;
    logic [IterW-1:0] iters;
    logic [DivW-1:0]  dividend;
    logic [DenW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quot;
  } div_rsp_t;

endpackage

### sv/ucb1_child_select.sv
// ----------------------------------------------------------------------------
// ucb1_child_select
// UCB1 child selection: scores each child in Q.16 and keeps the running best
// over a selection, emitting the winner on the last child.
// ----------------------------------------------------------------------------
//  channel | handshake                    | payload
//  in      | in_valid / in_stall (out)    | child_score_sum .. last_child
//  out     | out_valid / out_stall (in)   | best_index, best_value, too_many_children
//  cfg     | cfg_wen                      | cfg_wdata (explore_weight)
//
//  A visited child runs the mean divide, 16 squaring rounds for the logarithm,
//  the ln/visits divide, 19 square root steps, then multiply, compare and
//  handshake; the next word is taken only once it is done. With a parent
//  count of 0 or 1 the logarithm is skipped. Unvisited children skip the
//  arithmetic and ignored ones go straight to finish. The divider and the
//  single 32x32 multiplier do the arithmetic. Reset is synchronous and clears
//  all control state. A stalled result holds the block only when the next
//  last child finishes.
// ----------------------------------------------------------------------------
module ucb1_child_select #(
  parameter int unsigned MAX_CHILDREN = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [47:0] child_score_sum,
  input  logic [23:0]        child_visits,
  input  logic               child_is_white,
  input  logic [23:0]        node_visits,
  input  logic               parent_is_white,
  input  logic               last_child,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         best_index,
  output logic signed [47:0] best_value,
  output logic               too_many_children
);

  localparam logic signed [49:0] ValMaxExt = 50'(ucb1_pkg::VAL_MAX);
  localparam logic signed [49:0] ValMinExt = 50'(ucb1_pkg::VAL_MIN);

  ucb1_pkg::state_t state;
  ucb1_pkg::div_req_t div_req;
  ucb1_pkg::div_rsp_t div_rsp;

  logic [23:0]        explore_weight;
  logic signed [47:0] sum;
  logic [23:0]        visits;
  logic               cwhite;
  logic [23:0]        pvisits;
  logic               pwhite;
  logic               last;

  logic signed [47:0] run_best;
  logic [7:0]         run_index;
  logic [8:0]         child_count;
  logic               overflow_seen;

  logic [47:0]        mag;
  logic [4:0]         ln_n;
  logic [30:0]        ln_m;
  logic [15:0]        ln_frac;
  logic [3:0]         sq_cnt;
  logic [37:0]        rad;
  logic [21:0]        srem;
  logic [18:0]        root;
  logic [4:0]         rt_cnt;
  logic signed [47:0] value;

  logic [31:0]        mul_a;
  logic [31:0]        mul_b;
  logic [63:0]        prod;

  logic [4:0]         lead;
  logic [54:0]        m_wide;
  logic [31:0]        m_sq;
  logic [21:0]        rem_try;
  logic [21:0]        trial;
  logic [20:0]        ln_val;
  logic [26:0]        t_val;
  logic signed [49:0] mean_ext;
  logic signed [49:0] r_ext;
  logic signed [47:0] r_sat;
  logic               better;
  logic               accept;
  logic               emit;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != ucb1_pkg::S_IDLE);
  assign emit     = (state == ucb1_pkg::S_FIN) && last && (!out_valid || !out_stall);

  always_comb begin
    lead = '0;
    for (int i = 1; i < 24; i++) begin
      if (pvisits[i]) lead = 5'(i);
    end
    m_wide  = {31'b0, pvisits} << (5'd30 - lead);
    m_sq    = prod[61:30];
    rem_try = {srem[19:0], rad[37:36]};
    trial   = {1'b0, root, 2'b01};
    ln_val  = prod[36:16];
    t_val   = prod[42:16];
    mean_ext = sum[47] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    r_ext    = cwhite ? mean_ext - $signed({23'b0, t_val})
                      : mean_ext + $signed({23'b0, t_val});
    if (r_ext > ValMaxExt) r_sat = ucb1_pkg::VAL_MAX;
    else if (r_ext < ValMinExt) r_sat = ucb1_pkg::VAL_MIN;
    else r_sat = r_ext[47:0];
    better = pwhite ? (value > run_best) : (value < run_best);
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      ucb1_pkg::S_SQ: begin
        mul_a = {1'b0, ln_m};
        mul_b = {1'b0, ln_m};
      end
      ucb1_pkg::S_LNMUL: begin
        mul_a = {11'b0, ln_n, ln_frac};
        mul_b = {16'b0, ucb1_pkg::LN2_Q16};
      end
      default: begin
        mul_a = {8'b0, explore_weight};
        mul_b = {13'b0, root};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    div_req.divisor = visits;
    div_req.start   = 1'b0;
    div_req.iters   = ucb1_pkg::Q_ITERS;
    div_req.dividend = {ln_val, 27'b0};
    case (state)
      ucb1_pkg::S_EVAL: begin
        div_req.start = (child_count < 9'(MAX_CHILDREN)) && (visits != '0);
        div_req.iters = ucb1_pkg::MEAN_ITERS;
        div_req.dividend = sum[47] ? 48'(48'd0 - sum) : sum;
      end
      ucb1_pkg::S_MEAN: begin
        div_req.start = div_rsp.done && (lead == '0);
        div_req.dividend = '0;
      end
      ucb1_pkg::S_LNGET: begin
        div_req.start = 1'b1;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  ucb1_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      sum     <= child_score_sum;
      visits  <= child_visits;
      cwhite  <= child_is_white;
      pvisits <= node_visits;
      pwhite  <= parent_is_white;
      last    <= last_child;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ucb1_pkg::S_IDLE;
      explore_weight <= ucb1_pkg::EXPLORE_RESET;
      run_best       <= -ucb1_pkg::START_BOUND;
      run_index      <= '0;
      child_count    <= '0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wen) explore_weight <= cfg_wdata;
      if (emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        ucb1_pkg::S_IDLE: begin
          if (accept) begin
            if (child_count == '0) begin
              run_best  <= parent_is_white ? -ucb1_pkg::START_BOUND
                                           : ucb1_pkg::START_BOUND;
              run_index <= '0;
            end
            state <= ucb1_pkg::S_EVAL;
          end
        end
        ucb1_pkg::S_EVAL: begin
          if (child_count >= 9'(MAX_CHILDREN)) begin
            overflow_seen <= 1'b1;
            state <= ucb1_pkg::S_FIN;
          end else if (visits == '0) begin
            value <= cwhite ? -ucb1_pkg::UNVISITED_VALUE : ucb1_pkg::UNVISITED_VALUE;
            state <= ucb1_pkg::S_CMP;
          end else begin
            state <= ucb1_pkg::S_MEAN;
          end
        end
        ucb1_pkg::S_MEAN: begin
          if (div_rsp.done) begin
            mag     <= div_rsp.quot;
            ln_n    <= lead;
            ln_m    <= m_wide[30:0];
            ln_frac <= '0;
            sq_cnt  <= '0;
            state   <= (lead == '0) ? ucb1_pkg::S_QDIV : ucb1_pkg::S_SQ;
          end
        end
        ucb1_pkg::S_SQ: begin
          state <= ucb1_pkg::S_SQU;
        end
        ucb1_pkg::S_SQU: begin
          // renormalise into [1,2) and shift the bit into the fraction
          ln_frac <= {ln_frac[14:0], m_sq[31]};
          ln_m    <= m_sq[31] ? m_sq[31:1] : m_sq[30:0];
          sq_cnt  <= sq_cnt + 1'b1;
          state   <= (sq_cnt == 4'd15) ? ucb1_pkg::S_LNMUL : ucb1_pkg::S_SQ;
        end
        ucb1_pkg::S_LNMUL: begin
          state <= ucb1_pkg::S_LNGET;
        end
        ucb1_pkg::S_LNGET: begin
          state <= ucb1_pkg::S_QDIV;
        end
        ucb1_pkg::S_QDIV: begin
          if (div_rsp.done) begin
            rad    <= {1'b0, div_rsp.quot[20:0], 16'b0};
            srem   <= '0;
            root   <= '0;
            rt_cnt <= '0;
            state  <= ucb1_pkg::S_SQRT;
          end
        end
        ucb1_pkg::S_SQRT: begin
          rad <= {rad[35:0], 2'b00};
          if (rem_try >= trial) begin
            srem <= rem_try - trial;
            root <= {root[17:0], 1'b1};
          end else begin
            srem <= rem_try;
            root <= {root[17:0], 1'b0};
          end
          rt_cnt <= rt_cnt + 1'b1;
          if (rt_cnt == 5'd18) state <= ucb1_pkg::S_TMUL;
        end
        ucb1_pkg::S_TMUL: begin
          state <= ucb1_pkg::S_TADD;
        end
        ucb1_pkg::S_TADD: begin
          value <= r_sat;
          state <= ucb1_pkg::S_CMP;
        end
        ucb1_pkg::S_CMP: begin
          if (better) begin
            run_best  <= value;
            run_index <= child_count[7:0];
          end
          child_count <= child_count + 1'b1;
          state <= ucb1_pkg::S_FIN;
        end
        ucb1_pkg::S_FIN: begin
          if (!last) begin
            state <= ucb1_pkg::S_IDLE;
          end else if (!out_valid || !out_stall) begin
            best_index        <= run_index;
            best_value        <= run_best;
            too_many_children <= overflow_seen;
            run_best          <= -ucb1_pkg::START_BOUND;
            run_index         <= '0;
            child_count       <= '0;
            overflow_seen     <= 1'b0;
            state             <= ucb1_pkg::S_IDLE;
          end
        end
        default: begin
          state <= ucb1_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    child_count <= 9'(MAX_CHILDREN))
    else $error("child count past limit");

  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ucb1_pkg::S_FIN))
    else $error("result raised outside finish");

  a_div_done_place: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ucb1_pkg::S_MEAN || state == ucb1_pkg::S_QDIV))
    else $error("divider finished with nobody waiting");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");
`endif

endmodule

### sv/ucb1_div.sv
// ----------------------------------------------------------------------------
// ucb1_div
// Restoring divider, one quotient bit per cycle. The dividend is consumed
// from its top bit; after N iterations the quotient holds the top N bits
// divided by the divisor.
// ----------------------------------------------------------------------------
module ucb1_div (
  input  logic              clk,
  input  logic              rst,
  input  ucb1_pkg::div_req_t req,
  output ucb1_pkg::div_rsp_t rsp
);

  logic [ucb1_pkg::DenW-1:0]  rem;
  logic [ucb1_pkg::DivW-1:0]  dvd;
  logic [ucb1_pkg::DivW-1:0]  quot;
  logic [ucb1_pkg::IterW-1:0] cnt;
  logic                       busy;
  logic                       done;
  logic [ucb1_pkg::DenW:0]    rem_sh;
  logic                       qbit;
  logic [ucb1_pkg::DenW:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem, dvd[ucb1_pkg::DivW-1]};
    qbit    = (rem_sh >= {1'b0, req.divisor});
    rem_sub = rem_sh - {1'b0, req.divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ucb1_pkg::IterW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      dvd  <= req.dividend;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? rem_sub[ucb1_pkg::DenW-1:0] : rem_sh[ucb1_pkg::DenW-1:0];
      dvd  <= {dvd[ucb1_pkg::DivW-2:0], 1'b0};
      quot <= {quot[ucb1_pkg::DivW-2:0], qbit};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
